### src/frame_bitmap_allocator_assert.svh
`ifndef FRAME_BITMAP_ALLOCATOR_ASSERT_SVH
`define FRAME_BITMAP_ALLOCATOR_ASSERT_SVH

`ifndef SYNTH
`define FBA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("frame bitmap allocator check failed");
`define FBA_ASSERT_NEXT(lbl, clk, rst_n, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("frame bitmap allocator sequence check failed");
`else
`define FBA_ASSERT(lbl, clk, rst_n, prop)
`define FBA_ASSERT_NEXT(lbl, clk, rst_n, cond, expr)
`endif

`endif

### src/fba_pkg.sv
package fba_pkg;

    localparam int MAX_FRAMES = 4096;
    localparam int WORD_BITS  = 32;
    localparam int NWORDS     = MAX_FRAMES / WORD_BITS;
    localparam int WORD_AW    = $clog2(NWORDS);
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int SCAN_W     = WORD_AW + 1;
    localparam int FRAME_W    = 12;
    localparam int FC_W       = 13;
    localparam int WCNT_W     = FC_W - BIT_W;

    localparam logic [FC_W-1:0] FRAME_COUNT_RST = FC_W'(4096);

    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_FREE  = 2'd1;
    localparam logic [1:0] MODE_TEST  = 2'd2;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_NOP  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic       load_item;
        logic       rd_en;
        logic       rd_scan;
        logic       scan_inc;
        logic       grant;
        logic       free_wr;
        logic       test_rd;
        logic       set_status;
        logic [1:0] status;
        logic       out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic       fi_zero;
        logic       words_zero;
        logic       word_full;
        logic       scan_end;
        logic       out_free;
    } t_dp_stat;

endpackage

### src/fba_ctrl.sv
module fba_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  fba_pkg::t_dp_stat i_stat,
    output fba_pkg::t_dp_cmd  o_cmd
);
    import fba_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_START  = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_GRANT  = 3'd3;
    localparam logic [2:0] S_RMW    = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_START;
                end
            end
            S_START: begin
                case (i_stat.mode)
                    MODE_ALLOC: begin
                        if (!i_stat.fi_zero) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_NOP;
                            n_state          = S_FINISH;
                        end else if (i_stat.words_zero) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_FULL;
                            n_state          = S_FINISH;
                        end else begin
                            o_cmd.rd_en    = 1'b1;
                            o_cmd.rd_scan  = 1'b1;
                            o_cmd.scan_inc = 1'b1;
                            n_state        = S_SCAN;
                        end
                    end
                    MODE_FREE: begin
                        if (i_stat.fi_zero) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_NOP;
                            n_state          = S_FINISH;
                        end else begin
                            o_cmd.rd_en = 1'b1;
                            n_state     = S_RMW;
                        end
                    end
                    MODE_TEST: begin
                        o_cmd.rd_en = 1'b1;
                        n_state     = S_RMW;
                    end
                    default: begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_NOP;
                        n_state          = S_FINISH;
                    end
                endcase
            end
            S_SCAN: begin
                if (!i_stat.word_full) begin
                    n_state = S_GRANT;
                end else if (i_stat.scan_end) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_FULL;
                    n_state          = S_FINISH;
                end else begin
                    o_cmd.rd_en    = 1'b1;
                    o_cmd.rd_scan  = 1'b1;
                    o_cmd.scan_inc = 1'b1;
                end
            end
            S_GRANT: begin
                o_cmd.grant = 1'b1;
                n_state     = S_FINISH;
            end
            S_RMW: begin
                if (i_stat.mode == MODE_FREE) begin
                    o_cmd.free_wr = 1'b1;
                end else begin
                    o_cmd.test_rd = 1'b1;
                end
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### src/fba_datapath.sv
`include "frame_bitmap_allocator_assert.svh"

module fba_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  fba_pkg::t_dp_cmd            i_cmd,
    output fba_pkg::t_dp_stat           o_stat,
    input  logic [1:0]                  i_mode,
    input  logic [fba_pkg::FRAME_W-1:0] i_frame_index,
    input  logic                        i_is_kernel,
    input  logic                        i_is_writeable,
    input  logic                        i_cfg_valid,
    input  logic [fba_pkg::FC_W-1:0]    i_frame_count,
    input  logic                        i_stall,
    output logic                        o_valid,
    output logic [fba_pkg::FRAME_W-1:0] o_frame_out,
    output logic                        o_present,
    output logic                        o_writable,
    output logic                        o_user_access,
    output logic                        o_frame_used,
    output logic [1:0]                  o_status
);
    import fba_pkg::*;

    logic [FC_W-1:0]      r_frame_count;
    logic [1:0]           r_mode;
    logic [FRAME_W-1:0]   r_fi;
    logic                 r_kern;
    logic                 r_wr;

    logic [WORD_BITS-1:0] r_mem [NWORDS];
    logic [NWORDS-1:0]    r_wvalid;
    logic [WORD_BITS-1:0] r_rd_data;
    logic [SCAN_W-1:0]    r_scan_addr;

    logic [FRAME_W-1:0]   r_pend_frame;
    logic                 r_pend_present;
    logic                 r_pend_used;
    logic [1:0]           r_pend_status;

    logic                 r_out_valid;
    logic [FRAME_W-1:0]   r_out_frame;
    logic                 r_out_present;
    logic                 r_out_writable;
    logic                 r_out_user;
    logic                 r_out_used;
    logic [1:0]           r_out_status;

    logic [WCNT_W-1:0]    words;
    logic [WORD_AW-1:0]   fi_word;
    logic [BIT_W-1:0]     fi_bit;
    logic [WORD_AW-1:0]   rd_addr;
    logic [WORD_AW-1:0]   scan_word;
    logic [BIT_W-1:0]     hit_bit;
    logic                 wr_en;
    logic [WORD_AW-1:0]   wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic [SCAN_W-1:0]    scan_prev;

    assign fi_word   = r_fi[FRAME_W-1 -: WORD_AW];
    assign fi_bit    = r_fi[BIT_W-1:0];
    assign scan_prev = r_scan_addr - 1'b1;
    assign scan_word = scan_prev[WORD_AW-1:0];
    assign rd_addr   = i_cmd.rd_scan ? r_scan_addr[WORD_AW-1:0] : fi_word;

    always_comb begin
        if (r_frame_count[FC_W-1:BIT_W] > WCNT_W'(NWORDS)) begin
            words = WCNT_W'(NWORDS);
        end else begin
            words = r_frame_count[FC_W-1:BIT_W];
        end
    end

    always_comb begin
        hit_bit = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!r_rd_data[i]) begin
                hit_bit = BIT_W'(i);
            end
        end
    end

    always_comb begin
        wr_en   = i_cmd.grant | i_cmd.free_wr;
        wr_addr = i_cmd.grant ? scan_word : fi_word;
        if (i_cmd.grant) begin
            wr_data = r_rd_data | (WORD_BITS'(1) << hit_bit);
        end else begin
            wr_data = r_rd_data & ~(WORD_BITS'(1) << fi_bit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= FRAME_COUNT_RST;
        end else if (i_cfg_valid) begin
            r_frame_count <= i_frame_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_wvalid[rd_addr] ? r_mem[rd_addr] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvalid <= '0;
        end else if (wr_en) begin
            r_wvalid[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_mode         <= i_mode;
            r_fi           <= i_frame_index;
            r_kern         <= i_is_kernel;
            r_wr           <= i_is_writeable;
            r_scan_addr    <= '0;
            r_pend_frame   <= i_frame_index;
            r_pend_present <= 1'b0;
            r_pend_used    <= 1'b0;
            r_pend_status  <= ST_DONE;
        end else begin
            if (i_cmd.scan_inc) begin
                r_scan_addr <= r_scan_addr + 1'b1;
            end
            if (i_cmd.set_status) begin
                r_pend_status <= i_cmd.status;
            end
            if (i_cmd.grant) begin
                r_pend_frame   <= {scan_word, hit_bit};
                r_pend_present <= 1'b1;
            end
            if (i_cmd.test_rd) begin
                r_pend_used <= r_rd_data[fi_bit];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_frame    <= r_pend_frame;
            r_out_present  <= r_pend_present;
            r_out_writable <= r_pend_present & r_wr;
            r_out_user     <= r_pend_present & ~r_kern;
            r_out_used     <= r_pend_used;
            r_out_status   <= r_pend_status;
        end
    end

    assign o_stat.mode       = r_mode;
    assign o_stat.fi_zero    = (r_fi == '0);
    assign o_stat.words_zero = (words == '0);
    assign o_stat.word_full  = &r_rd_data;
    assign o_stat.scan_end   = (WCNT_W'(r_scan_addr) == words);
    assign o_stat.out_free   = ~r_out_valid | ~i_stall;

    assign o_valid       = r_out_valid;
    assign o_frame_out   = r_out_frame;
    assign o_present     = r_out_present;
    assign o_writable    = r_out_writable;
    assign o_user_access = r_out_user;
    assign o_frame_used  = r_out_used;
    assign o_status      = r_out_status;

    `FBA_ASSERT(a_grant_has_zero, i_clk, i_rst_n, i_cmd.grant |-> !(&r_rd_data))
    `FBA_ASSERT(a_scan_in_range, i_clk, i_rst_n, i_cmd.scan_inc |-> (WCNT_W'(r_scan_addr) < words))
    `FBA_ASSERT(a_load_when_free, i_clk, i_rst_n, i_cmd.out_load |-> (!r_out_valid || !i_stall))
    `FBA_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, i_cmd.out_load, r_out_valid)

endmodule

### src/frame_bitmap_allocator.sv
// Bitmap page frame allocator with one used bit per frame, 4096 frames held in
// 128 words of 32 bits, all free after reset. An allocate scans the words below
// frame_count from the lowest, reading one bitmap word per cycle from a single
// read port. One item is worked on at a time; a finished result waits in the
// output register while the next item is taken in. The frame_count register may
// be written only while the block is idle.
module frame_bitmap_allocator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_mode,
    input  logic [fba_pkg::FRAME_W-1:0] i_frame_index,
    input  logic                        i_is_kernel,
    input  logic                        i_is_writeable,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [fba_pkg::FRAME_W-1:0] o_frame_out,
    output logic                        o_present,
    output logic                        o_writable,
    output logic                        o_user_access,
    output logic                        o_frame_used,
    output logic [1:0]                  o_status,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [fba_pkg::FC_W-1:0]    i_frame_count
);
    import fba_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    fba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    fba_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_mode         (i_mode),
        .i_frame_index  (i_frame_index),
        .i_is_kernel    (i_is_kernel),
        .i_is_writeable (i_is_writeable),
        .i_cfg_valid    (i_cfg_valid & o_cfg_ready),
        .i_frame_count  (i_frame_count),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_frame_out    (o_frame_out),
        .o_present      (o_present),
        .o_writable     (o_writable),
        .o_user_access  (o_user_access),
        .o_frame_used   (o_frame_used),
        .o_status       (o_status)
    );

endmodule

### test/frame_bitmap_allocator_checker.sv
module frame_bitmap_allocator_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        o_stall,
    input  logic [1:0]                  i_mode,
    input  logic [fba_pkg::FRAME_W-1:0] i_frame_index,
    input  logic                        i_is_kernel,
    input  logic                        i_is_writeable,
    input  logic                        o_valid,
    input  logic                        i_stall,
    input  logic [fba_pkg::FRAME_W-1:0] o_frame_out,
    input  logic                        o_present,
    input  logic                        o_writable,
    input  logic                        o_user_access,
    input  logic                        o_frame_used,
    input  logic [1:0]                  o_status,
    input  logic                        i_cfg_valid,
    input  logic                        o_cfg_ready,
    input  logic [fba_pkg::FC_W-1:0]    i_frame_count,
    output int                          o_fail_count,
    output int                          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import fba_pkg::*;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_out;
        logic               present;
        logic               writable;
        logic               user_access;
        logic               frame_used;
        logic [1:0]         status;
    } t_frame_reply;

    t_frame_reply         awaited_replies[$];
    logic [WORD_BITS-1:0] used_map [NWORDS];
    logic [FC_W-1:0]      managed_frames;
    int                   mismatches = 0;

    assign o_fail_count = mismatches;

    // Applies one request word to the local bitmap copy and returns the reply it should give.
    function automatic t_frame_reply serve_request(
        input logic [1:0]         mode,
        input logic [FRAME_W-1:0] fi,
        input logic               kern,
        input logic               wr
    );
        t_frame_reply r;
        int           span;
        logic         granted;
        r = '0;
        r.frame_out = fi;
        r.status = ST_DONE;
        case (mode)
            MODE_ALLOC: begin
                if (fi != '0) begin
                    r.status = ST_NOP;
                end else begin
                    span = int'(managed_frames) / WORD_BITS;
                    if (span > NWORDS) begin
                        span = NWORDS;
                    end
                    granted = 1'b0;
                    for (int w = 0; w < span && !granted; w++) begin
                        for (int b = 0; b < WORD_BITS && !granted; b++) begin
                            if (!used_map[w][b]) begin
                                used_map[w][b] = 1'b1;
                                r.frame_out = FRAME_W'(w * WORD_BITS + b);
                                granted = 1'b1;
                            end
                        end
                    end
                    if (granted) begin
                        r.present = 1'b1;
                        r.writable = wr;
                        r.user_access = !kern;
                    end else begin
                        r.status = ST_FULL;
                    end
                end
            end
            MODE_FREE: begin
                if (fi == '0) begin
                    r.status = ST_NOP;
                end else begin
                    used_map[fi / WORD_BITS][fi % WORD_BITS] = 1'b0;
                end
            end
            MODE_TEST: begin
                r.frame_used = used_map[fi / WORD_BITS][fi % WORD_BITS];
            end
            default: begin
                r.status = ST_NOP;
            end
        endcase
        return r;
    endfunction

    task automatic compare_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_frame_reply want;
        if (!i_rst_n) begin
            foreach (used_map[w]) begin
                used_map[w] = '0;
            end
            managed_frames = FRAME_COUNT_RST;
            awaited_replies.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                managed_frames = i_frame_count;
            end
            if (o_valid && !i_stall) begin
                if (awaited_replies.size() == 0) begin
                    $error("unexpected reply word: frame_out %0d, status %0d",
                           o_frame_out, o_status);
                    mismatches++;
                end else begin
                    want = awaited_replies.pop_front();
                    compare_field("frame_out", 32'(want.frame_out), 32'(o_frame_out));
                    compare_field("present", 32'(want.present), 32'(o_present));
                    compare_field("writable", 32'(want.writable), 32'(o_writable));
                    compare_field("user_access", 32'(want.user_access),
                                  32'(o_user_access));
                    compare_field("frame_used", 32'(want.frame_used), 32'(o_frame_used));
                    compare_field("status", 32'(want.status), 32'(o_status));
                end
            end
            if (i_valid && !o_stall) begin
                awaited_replies.push_back(serve_request(i_mode, i_frame_index,
                                                        i_is_kernel, i_is_writeable));
            end
        end
        o_pending <= awaited_replies.size();
    end

endmodule

### test/frame_bitmap_allocator_tb.sv
module frame_bitmap_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fba_pkg::*;

    localparam int         CYCLE_LIMIT   = 1_000_000;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         PHASE_WORDS   = 155;
    localparam logic [1:0] MODE_UNUSED   = 2'd3;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [1:0]         i_mode = MODE_TEST;
    logic [FRAME_W-1:0] i_frame_index = '0;
    logic               i_is_kernel = 1'b0;
    logic               i_is_writeable = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [FRAME_W-1:0] o_frame_out;
    logic               o_present;
    logic               o_writable;
    logic               o_user_access;
    logic               o_frame_used;
    logic [1:0]         o_status;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [FC_W-1:0]    i_frame_count = FRAME_COUNT_RST;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int frame_limit = MAX_FRAMES;

    frame_bitmap_allocator u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_mode         (i_mode),
        .i_frame_index  (i_frame_index),
        .i_is_kernel    (i_is_kernel),
        .i_is_writeable (i_is_writeable),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_frame_out    (o_frame_out),
        .o_present      (o_present),
        .o_writable     (o_writable),
        .o_user_access  (o_user_access),
        .o_frame_used   (o_frame_used),
        .o_status       (o_status),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_frame_count  (i_frame_count)
    );

    frame_bitmap_allocator_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_mode         (i_mode),
        .i_frame_index  (i_frame_index),
        .i_is_kernel    (i_is_kernel),
        .i_is_writeable (i_is_writeable),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_frame_out    (o_frame_out),
        .o_present      (o_present),
        .o_writable     (o_writable),
        .o_user_access  (o_user_access),
        .o_frame_used   (o_frame_used),
        .o_status       (o_status),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_frame_count  (i_frame_count),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_word(
        input logic [1:0]         mode,
        input logic [FRAME_W-1:0] fi,
        input logic               kern,
        input logic               wr
    );
        while ($urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= mode;
        i_frame_index <= fi;
        i_is_kernel <= kern;
        i_is_writeable <= wr;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_frame_count(input logic [FC_W-1:0] value);
        settle();
        i_cfg_valid <= 1'b1;
        i_frame_count <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        frame_limit = int'(value);
    endtask

    // Frees and tests mostly hit frames inside the managed range so that the
    // allocate path keeps finding and losing free frames.
    task automatic send_random_word();
        int                 pick;
        int                 span;
        logic [FRAME_W-1:0] fi;
        logic [FRAME_W-1:0] page_frame;
        pick = $urandom_range(0, 99);
        span = (frame_limit < WORD_BITS) ? WORD_BITS :
               (frame_limit > MAX_FRAMES) ? MAX_FRAMES : frame_limit;
        if ($urandom_range(0, 4) == 0) begin
            fi = FRAME_W'($urandom_range(0, MAX_FRAMES - 1));
        end else begin
            fi = FRAME_W'($urandom_range(1, span - 1));
        end
        page_frame = ($urandom_range(0, 9) == 0) ? FRAME_W'($urandom_range(1, MAX_FRAMES - 1)) :
                     '0;
        if (pick < 45) begin
            send_word(MODE_ALLOC, page_frame, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        end else if (pick < 72) begin
            send_word(MODE_FREE, fi, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else if (pick < 95) begin
            send_word(MODE_TEST, fi, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else begin
            send_word(MODE_UNUSED, FRAME_W'($urandom), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        int phase_frames[8];
        phase_frames = '{64, 4096, 32, 96, 8191, 160, 4096, 40};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(MODE_TEST, '0, 1'b0, 1'b0);
        send_word(MODE_ALLOC, '0, 1'b0, 1'b1);
        send_word(MODE_ALLOC, '0, 1'b1, 1'b0);
        send_word(MODE_ALLOC, 12'd4095, 1'b0, 1'b1);
        send_word(MODE_TEST, '0, 1'b1, 1'b1);
        send_word(MODE_TEST, 12'd4095, 1'b0, 1'b0);
        send_word(MODE_FREE, '0, 1'b0, 1'b0);
        send_word(MODE_FREE, 12'd1, 1'b0, 1'b0);
        send_word(MODE_FREE, 12'd2049, 1'b0, 1'b0);
        send_word(MODE_UNUSED, 12'hAAA, 1'b1, 1'b1);
        send_word(MODE_ALLOC, '0, 1'b1, 1'b1);
        send_word(MODE_FREE, 12'd4095, 1'b1, 1'b0);
        send_word(MODE_TEST, 12'd1, 1'b0, 1'b1);

        // Fewer frames than one bitmap word leaves nothing to scan.
        program_frame_count(13'd0);
        send_word(MODE_ALLOC, '0, 1'b0, 1'b1);
        program_frame_count(13'd31);
        send_word(MODE_ALLOC, '0, 1'b1, 1'b1);
        program_frame_count(13'd32);
        send_word(MODE_ALLOC, '0, 1'b0, 1'b0);
        program_frame_count(13'd8191);
        send_word(MODE_ALLOC, '0, 1'b1, 1'b0);

        for (int p = 0; p < 8; p++) begin
            program_frame_count(FC_W'(phase_frames[p]));
            case (p % 4)
                0: begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct = 58;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct = 0;
                    stall_pct = 58;
                end
                default: begin
                    idle_pct = 28;
                    stall_pct = 28;
                end
            endcase
            repeat (PHASE_WORDS) send_random_word();
        end

        settle();
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
